// File: hw/rtl/piecewise_linear_interpolator_top_defines.svh
// assertion macros used by the interpolator controller (pli_ctrl)
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_TOP_DEFINES_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define PLI_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define PLI_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/pli_pkg.sv
`timescale 1ns / 1ps

package pli_pkg;

    localparam int VW              = 32;
    localparam int IDXW            = 6;
    localparam int CNTW            = 7;
    localparam int DEF_MAX_POINTS  = 64;
    localparam logic [CNTW-1:0] COUNT_RESET = 7'd2;

    // multiplier operand is consumed in chunks of this many bits
    localparam int MULW = 16;
    localparam int PW   = ((VW + MULW - 1) / MULW) * MULW;
    localparam int NCH  = PW / MULW;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef struct packed {
        t_op                   opcode;
        logic [IDXW-1:0]       point_index;
        logic signed [VW-1:0]  point_x;
        logic signed [VW-1:0]  point_y;
        logic signed [VW-1:0]  query_x;
    } t_in;

    typedef struct packed {
        logic signed [VW-1:0]  result_y;
        logic                  in_range_flag;
    } t_out;

    typedef enum logic [1:0] {
        RD_ZERO,
        RD_J,
        RD_DOWN,
        RD_UP
    } t_rd_sel;

    typedef enum logic [2:0] {
        RES_HOLD,
        RES_LOW,
        RES_TOP,
        RES_YJ,
        RES_INTERP
    } t_res_sel;

    typedef struct packed {
        logic      load;
        logic      query_start;
        t_rd_sel   rd_sel;
        logic      j_dec;
        logic      save_j;
        logic      setup;
        logic      mul_step;
        logic      div_init;
        logic      div_step;
        t_res_sel  res_sel;
        logic      out_load;
    } t_cmd;

    typedef struct packed {
        logic below_first;
        logic hit;
        logic at_last;
        logic ascending;
    } t_status;

endpackage

// File: hw/rtl/pli_ctrl.sv
`timescale 1ns / 1ps
`include "piecewise_linear_interpolator_top_defines.svh"

module pli_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  pli_pkg::t_op     i_opcode,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  pli_pkg::t_status i_status,
    output pli_pkg::t_cmd    o_cmd
);
    import pli_pkg::*;

    localparam int CTW = $clog2(VW);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CMP0,
        S_SCAN,
        S_NEXT,
        S_MUL,
        S_DINIT,
        S_DIV,
        S_RES,
        S_FIN
    } t_state;

    t_state          r_state, n_state;
    logic [CTW-1:0]  r_cnt, n_cnt;
    logic            r_out_valid, n_out_valid;
    logic            in_acc;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_opcode == OP_QUERY) begin
                        o_cmd.query_start = 1'b1;
                        n_state           = S_CMP0;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_CMP0: begin
                // entry 0 is on the read port, fetch the top entry next
                o_cmd.rd_sel = RD_J;
                if (i_status.below_first) begin
                    o_cmd.res_sel = RES_LOW;
                    n_state       = S_FIN;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_status.hit) begin
                    if (i_status.at_last) begin
                        o_cmd.rd_sel  = RD_DOWN;
                        o_cmd.res_sel = RES_TOP;
                        n_state       = S_FIN;
                    end else begin
                        o_cmd.rd_sel = RD_UP;
                        o_cmd.save_j = 1'b1;
                        n_state      = S_NEXT;
                    end
                end else begin
                    o_cmd.rd_sel = RD_DOWN;
                    o_cmd.j_dec  = 1'b1;
                end
            end
            S_NEXT: begin
                if (!i_status.ascending) begin
                    o_cmd.res_sel = RES_YJ;
                    n_state       = S_FIN;
                end else begin
                    o_cmd.setup = 1'b1;
                    n_cnt       = '0;
                    n_state     = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (r_cnt == CTW'(NCH - 1)) begin
                    n_cnt   = '0;
                    n_state = S_DINIT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == CTW'(VW - 1)) begin
                    n_state = S_RES;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_RES: begin
                o_cmd.res_sel = RES_INTERP;
                n_state       = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    `PLI_ASSERT_NXT(a_query_busy, i_clk, i_rst_n, in_acc && (i_opcode == OP_QUERY), !o_in_ready, "query accepted but input still ready")
    `PLI_ASSERT_NXT(a_load_stays_idle, i_clk, i_rst_n, in_acc && (i_opcode == OP_LOAD), o_in_ready, "load transaction left the idle state")
    `PLI_ASSERT_NOW(a_out_slot_free, i_clk, i_rst_n, o_cmd.out_load, !r_out_valid || i_out_ready, "result overwrites a pending transaction")
    `PLI_ASSERT_NXT(a_out_shown, i_clk, i_rst_n, o_cmd.out_load, o_out_valid, "loaded result not presented")

endmodule

// File: hw/rtl/pli_dpath.sv
`timescale 1ns / 1ps

module pli_dpath #(
    parameter int MAX_POINTS = pli_pkg::DEF_MAX_POINTS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  pli_pkg::t_in              i_in_data,
    input  logic                      i_cfg_we,
    input  logic [pli_pkg::CNTW-1:0]  i_cfg_wdata,
    input  pli_pkg::t_cmd             i_cmd,
    output pli_pkg::t_status          o_status,
    output pli_pkg::t_out             o_out_data
);
    import pli_pkg::*;

    localparam int AW   = $clog2(MAX_POINTS);
    localparam int XW   = ((AW > IDXW) ? AW : IDXW) + 1;
    localparam int NW   = ((AW > CNTW) ? AW : CNTW) + 1;
    localparam int ACCW = VW + PW;

    // x in the upper half of each word, y in the lower
    logic [2*VW-1:0]       r_mem [MAX_POINTS];
    logic [2*VW-1:0]       r_rd;
    logic [CNTW-1:0]       r_count;
    logic [AW-1:0]         r_j;
    logic signed [VW-1:0]  r_xq, r_xj, r_yj, r_res;
    logic                  r_flag;
    logic [VW-1:0]         r_dx, r_mag, r_rem, r_quo;
    logic                  r_neg;
    logic [PW-1:0]         r_mq;
    logic [ACCW-1:0]       r_acc;
    t_out                  r_out;

    logic [XW-1:0]         slot_ext;
    logic                  slot_ok;
    logic [NW-1:0]         cnt_ext;
    logic [AW-1:0]         last;
    logic [AW-1:0]         raddr;
    logic signed [VW-1:0]  x_rd, y_rd;
    logic [VW-1:0]         dx, dq, mag;
    logic                  neg;
    logic [VW+MULW-1:0]    pp;
    logic [VW:0]           t_div, d_div;
    logic                  ge;

    assign slot_ext = XW'(i_in_data.point_index);
    assign slot_ok  = slot_ext < XW'(MAX_POINTS);

    // effective top index: count of zero acts as one, large counts clip
    assign cnt_ext = NW'(r_count);
    always_comb begin
        if (r_count == '0) begin
            last = '0;
        end else if (cnt_ext > NW'(MAX_POINTS)) begin
            last = AW'(MAX_POINTS - 1);
        end else begin
            last = AW'(cnt_ext - 1'b1);
        end
    end

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_ZERO: raddr = '0;
            RD_J:    raddr = r_j;
            RD_DOWN: raddr = (r_j == '0) ? '0 : r_j - 1'b1;
            RD_UP:   raddr = r_j + 1'b1;
            default: raddr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && slot_ok) begin
            r_mem[slot_ext[AW-1:0]] <= {i_in_data.point_x, i_in_data.point_y};
        end
        r_rd <= r_mem[raddr];
    end

    assign x_rd = r_rd[2*VW-1:VW];
    assign y_rd = r_rd[VW-1:0];

    assign o_status.below_first = x_rd > r_xq;
    assign o_status.hit         = x_rd <= r_xq;
    assign o_status.at_last     = (r_j == last);
    assign o_status.ascending   = x_rd > r_xj;

    // x[j] <= xq < x[j+1], so all three differences fit unsigned
    assign dx  = x_rd - r_xj;
    assign dq  = r_xq - r_xj;
    assign neg = y_rd < r_yj;
    assign mag = neg ? (r_yj - y_rd) : (y_rd - r_yj);

    assign pp = r_mag * r_mq[PW-1 -: MULW];

    assign t_div = {r_rem, r_quo[VW-1]};
    assign d_div = t_div - {1'b0, r_dx};
    assign ge    = t_div >= {1'b0, r_dx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_RESET;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.query_start) begin
            r_xq <= i_in_data.query_x;
            r_j  <= last;
        end else if (i_cmd.j_dec) begin
            r_j <= r_j - 1'b1;
        end
        if (i_cmd.save_j) begin
            r_xj <= x_rd;
            r_yj <= y_rd;
        end
        if (i_cmd.setup) begin
            r_dx  <= dx;
            r_mag <= mag;
            r_neg <= neg;
            r_mq  <= PW'(dq);
            r_acc <= '0;
        end
        // product built from the top chunk down
        if (i_cmd.mul_step) begin
            r_acc <= (r_acc << MULW) + ACCW'(pp);
            r_mq  <= r_mq << MULW;
        end
        // quotient is below 2^VW, so the top half is already under dx
        if (i_cmd.div_init) begin
            r_rem <= r_acc[2*VW-1:VW];
            r_quo <= r_acc[VW-1:0];
        end
        if (i_cmd.div_step) begin
            r_rem <= ge ? d_div[VW-1:0] : t_div[VW-1:0];
            r_quo <= {r_quo[VW-2:0], ge};
        end
        unique case (i_cmd.res_sel)
            RES_HOLD: begin
            end
            RES_LOW: begin
                r_res  <= y_rd;
                r_flag <= 1'b1;
            end
            RES_TOP: begin
                r_res  <= y_rd;
                r_flag <= 1'b0;
            end
            RES_YJ: begin
                r_res  <= r_yj;
                r_flag <= 1'b1;
            end
            RES_INTERP: begin
                r_res  <= r_neg ? (r_yj - r_quo) : (r_yj + r_quo);
                r_flag <= 1'b1;
            end
            default: begin
            end
        endcase
        if (i_cmd.out_load) begin
            r_out.result_y      <= r_res;
            r_out.in_range_flag <= r_flag;
        end
    end

    assign o_out_data = r_out;

endmodule

// File: hw/rtl/piecewise_linear_interpolator_top.sv
// piecewise linear interpolation table
// input channel (i_in_valid / o_in_ready / i_in_data): a load transaction
// (opcode 0) writes one breakpoint into the slot given by point_index and
// produces no result; a query transaction (opcode 1) produces one result.
// a load leaves the input ready for the next transaction. a query reads one
// table entry per cycle while it searches down from the last breakpoint in
// use, then multiplies and divides one quotient bit per cycle.
// one query is in flight at a time; the next transaction is taken as soon
// as the result sits in the output register.
// output channel (o_out_valid / i_out_ready / o_out_data): the result waits
// in its register while the receiver stalls; loads are still accepted then,
// and a following query stops just before delivery until the slot frees.
// i_cfg_we / i_cfg_wdata write point_count; write it only while idle (not enforced by the block).
// synchronous reset empties the output and sets point_count to 2; table
// contents are undefined until loaded.
`timescale 1ns / 1ps

module piecewise_linear_interpolator_top #(
    parameter int MAX_POINTS = pli_pkg::DEF_MAX_POINTS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  pli_pkg::t_in              i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output pli_pkg::t_out             o_out_data,
    input  logic                      i_cfg_we,
    input  logic [pli_pkg::CNTW-1:0]  i_cfg_wdata
);
    import pli_pkg::*;

    t_cmd    cmd;
    t_status status;

    pli_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_in_data.opcode),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    pli_dpath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_data  (o_out_data)
    );

endmodule

// File: sim/piecewise_linear_interpolator_top_tb.sv
`timescale 1ns / 1ps

module piecewise_linear_interpolator_top_tb;
    import pli_pkg::*;

    localparam int     SLOTS         = DEF_MAX_POINTS;
    localparam int     SETTLE_CYCLES = 160;
    localparam int     QUIET_LIMIT   = 4000;
    localparam int     PHASE_ITEMS   = 280;
    localparam longint X_MIN         = 64'shFFFF_FFFF_8000_0000;
    localparam longint X_MAX         = 64'sh0000_0000_7FFF_FFFF;

    logic            i_clk     = 1'b0;
    logic            i_rst_n   = 1'b0;
    logic            in_valid  = 1'b0;
    t_in             in_data   = '0;
    logic            out_ready = 1'b0;
    logic            cfg_we    = 1'b0;
    logic [CNTW-1:0] cfg_wdata = '0;
    logic            o_in_ready;
    logic            o_out_valid;
    t_out            o_out_data;

    // breakpoint table and point count as the block should hold them
    longint          table_x [SLOTS];
    longint          table_y [SLOTS];
    logic [CNTW-1:0] point_count = COUNT_RESET;
    t_out            expected_y_q [$];
    t_out            want_y;

    int errors        = 0;
    int loads_sent    = 0;
    int queries_sent  = 0;
    int results_seen  = 0;
    int count_writes  = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int quiet_cycles  = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    piecewise_linear_interpolator_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= 40) begin
            $display("mismatch at %0t: %s", $time, what);
        end
    endtask

    function automatic longint unsigned rand64();
        return {$urandom, $urandom};
    endfunction

    // inclusive range, span never wider than 32 bits here
    function automatic longint rand_between(longint lo, longint hi);
        longint unsigned span;
        span = hi - lo;
        return lo + longint'(rand64() % (span + 1));
    endfunction

    function automatic longint rand_value();
        case ($urandom_range(7))
            0: return X_MIN;
            1: return X_MAX;
            2, 3: return rand_between(-262144, 262144);
            default: return longint'($signed($urandom));
        endcase
    endfunction

    function automatic int points_in_use();
        if (point_count == 0) return 1;
        if (point_count > SLOTS) return SLOTS;
        return int'(point_count);
    endfunction

    function automatic t_out interpolate(logic signed [VW-1:0] qx);
        longint          xq, dy, res;
        longint unsigned mag, dx, dq, q;
        int              n, j;
        t_out            r;
        n = points_in_use();
        xq = qx;
        r.in_range_flag = 1'b1;
        if (xq < table_x[0]) begin
            // below the first point the flag stays set
            res = table_y[0];
        end else begin
            j = n - 1;
            while (j > 0 && table_x[j] > xq) j--;
            if (j == n - 1) begin
                res = table_y[n-1];
                r.in_range_flag = 1'b0;
            end else if (table_x[j+1] <= table_x[j]) begin
                res = table_y[j];
            end else begin
                dy = table_y[j+1] - table_y[j];
                dx = table_x[j+1] - table_x[j];
                dq = xq - table_x[j];
                mag = (dy < 0) ? -dy : dy;
                // full product first, then truncating divide on the magnitude
                q = mag * dq / dx;
                res = (dy < 0) ? table_y[j] - longint'(q) : table_y[j] + longint'(q);
            end
        end
        r.result_y = res[VW-1:0];
        return r;
    endfunction

    function automatic t_in load_item(int slot, longint x, longint y);
        t_in it;
        it.opcode      = OP_LOAD;
        it.point_index = IDXW'(slot);
        it.point_x     = x[VW-1:0];
        it.point_y     = y[VW-1:0];
        it.query_x     = $urandom;
        return it;
    endfunction

    function automatic t_in query_item(longint qx);
        t_in it;
        it.opcode      = OP_QUERY;
        it.point_index = IDXW'($urandom);
        it.point_x     = $urandom;
        it.point_y     = $urandom;
        it.query_x     = qx[VW-1:0];
        return it;
    endfunction

    // valid is only lowered for an idle gap or by settle(), never around a back-to-back transaction
    task automatic send_item(input t_in item);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (item.opcode == OP_LOAD) begin
            table_x[item.point_index] = item.point_x;
            table_y[item.point_index] = item.point_y;
            loads_sent++;
        end else begin
            expected_y_q.push_back(interpolate(item.query_x));
            queries_sent++;
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (expected_y_q.size() != 0) @(posedge i_clk);
        // a trailing load may still be in hand
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_point_count(input logic [CNTW-1:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        point_count = value;
        count_writes++;
    endtask

    task automatic load_table(input int n);
        longint xs [SLOTS];
        longint widest, total;
        int     shape;
        bit     downward;
        shape    = $urandom_range(9);
        downward = $urandom_range(1);
        widest   = (shape < 3) ? 64'sd16 : (shape < 6) ? 64'sd524288 : 64'sd4294967295 / n;
        total    = 0;
        for (int k = 1; k < n; k++) begin
            xs[k] = rand_between(1, widest);
            total += xs[k];
        end
        xs[0] = rand_between(X_MIN, X_MAX - total);
        for (int k = 1; k < n; k++) begin
            xs[k] = xs[k-1] + xs[k];
        end
        // now and then an unordered table with possible repeats
        if (shape == 9) begin
            for (int k = 0; k < n; k++) xs[k] = rand_between(X_MIN, X_MAX);
        end
        for (int k = 0; k < n; k++) begin
            send_item(load_item(downward ? n - 1 - k : k, xs[downward ? n - 1 - k : k],
                                rand_value()));
        end
    endtask

    function automatic longint pick_query_x(int n);
        int k;
        k = $urandom_range(n - 1);
        case ($urandom_range(11))
            0: return (table_x[0] > X_MIN) ? rand_between(X_MIN, table_x[0] - 1) : X_MIN;
            1: return table_x[k];
            2: return table_x[k] + 1;
            3: return table_x[k] - 1;
            4, 5, 6, 7: begin
                if (k + 1 < n && table_x[k+1] > table_x[k])
                    return rand_between(table_x[k], table_x[k+1] - 1);
                return rand_between(X_MIN, X_MAX);
            end
            8: return rand_between(table_x[n-1], X_MAX);
            9: return X_MIN;
            10: return X_MAX;
            default: return rand_between(X_MIN, X_MAX);
        endcase
    endfunction

    function automatic logic [CNTW-1:0] pick_count(int seq);
        int r;
        if (seq == 0) return CNTW'(127);
        if (seq == 1) return CNTW'(SLOTS);
        r = $urandom_range(99);
        if (r < 4) return CNTW'($urandom_range(127, SLOTS + 1));
        if (r < 8) return CNTW'(SLOTS);
        if (r < 14) return CNTW'($urandom_range(1));
        if (r < 24) return CNTW'($urandom_range(SLOTS - 1, 10));
        return CNTW'($urandom_range(9, 2));
    endfunction

    task automatic run_sequence(input int seq);
        int n;
        if (seq < 2 || $urandom_range(9) < 7) begin
            set_point_count(pick_count(seq));
            n = points_in_use();
            load_table(n);
        end else begin
            // partial rewrite of a table already in use
            n = points_in_use();
            repeat ($urandom_range(4, 1)) begin
                send_item(load_item($urandom_range(n - 1), rand_value(), rand_value()));
            end
        end
        repeat ($urandom_range(24, 6)) begin
            case ($urandom_range(9))
                0: send_item(load_item($urandom_range(SLOTS - 1), rand_value(), rand_value()));
                1: send_item(query_item(rand_between(X_MIN, X_MAX)));
                default: send_item(query_item(pick_query_x(n)));
            endcase
        end
    endtask

    task automatic test_default_count();
        send_item(load_item(0, -65536, 196608));
        send_item(load_item(1, 131072, -327680));
        send_item(query_item(-131072));
        send_item(query_item(-65536));
        send_item(query_item(32768));
        send_item(query_item(131072));
        send_item(query_item(X_MAX));
    endtask

    // widest possible dx and dy, with y falling across the table
    task automatic test_full_range();
        send_item(load_item(0, X_MIN, X_MAX));
        send_item(load_item(1, X_MAX, X_MIN));
        send_item(query_item(X_MIN));
        send_item(query_item(0));
        send_item(query_item(X_MAX - 1));
    endtask

    task automatic test_odd_tables();
        set_point_count(CNTW'(3));
        send_item(load_item(0, 0, 10));
        send_item(load_item(1, 65536, 20));
        send_item(load_item(2, 65536, 30));
        send_item(query_item(65536));
        send_item(query_item(32768));
        // last point now below its neighbour
        send_item(load_item(2, 32768, -30));
        send_item(query_item(40000));
    endtask

    task automatic test_count_limits();
        set_point_count(CNTW'(0));
        send_item(query_item(-1));
        send_item(query_item(X_MAX));
        set_point_count(CNTW'(1));
        send_item(load_item(SLOTS - 1, rand_value(), rand_value()));
        send_item(query_item(0));
    endtask

    task automatic test_random_tables();
        int seq, start_total;
        seq = 0;
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 79;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 79;
                end
                default: begin
                    send_idle_pct = 27;
                    stall_pct     = 27;
                end
            endcase
            start_total = loads_sent + queries_sent;
            while (loads_sent + queries_sent - start_total < PHASE_ITEMS) begin
                run_sequence(seq);
                seq++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        out_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            results_seen++;
            if (expected_y_q.size() == 0) begin
                report_mismatch($sformatf("result %0d with no query outstanding", results_seen));
            end else begin
                want_y = expected_y_q.pop_front();
                if (o_out_data.result_y !== want_y.result_y)
                    report_mismatch($sformatf("result %0d: y %h, expected %h", results_seen,
                                              o_out_data.result_y, want_y.result_y));
                if (o_out_data.in_range_flag !== want_y.in_range_flag)
                    report_mismatch($sformatf("result %0d: flag %b, expected %b", results_seen,
                                              o_out_data.in_range_flag,
                                              want_y.in_range_flag));
            end
        end
    end

    // ends the run if no transaction moves for too long
    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_count();
        test_full_range();
        test_odd_tables();
        test_count_limits();
        test_random_tables();
        settle();
        $display("covered %0d breakpoint loads and %0d queries, %0d results checked",
                 loads_sent, queries_sent, results_seen);
        $display("%0d point count writes incl. zero, one, full table and overrange",
                 count_writes);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
